### rtl/core/pgfj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgfj_pkg;

    localparam int AXES     = 3;
    localparam int AXW      = 2;
    localparam int DIFFW    = 33;
    localparam int IDW      = 24;
    localparam int QDEPTH   = 2;
    localparam int DW       = 50;
    localparam int SW       = 51;
    localparam int SQNW     = DW + 16;
    localparam int ROOTW    = SQNW / 2;
    localparam int DENW     = DW + ROOTW;
    localparam int DIVSTEPS = 64;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_NEIGHBOUR = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_NEIGHBOUR,
        KIND_SKIP
    } kind_t;

    typedef struct packed {
        kind_t                        kind;
        logic                         last;
        logic [31:0]                  mass;
        logic [AXES-1:0][DIFFW-1:0]   dx;
        logic [AXES-1:0][DIFFW-1:0]   dv;
    } entry_t;

    typedef struct packed {
        logic [AXES-1:0][63:0] acc;
        logic [AXES-1:0][63:0] jerk;
        logic                  sat;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_XX,
        ST_MUL_XV,
        ST_FLOOR,
        ST_ROOT,
        ST_DEN,
        ST_MUL_XS,
        ST_DIV_Q,
        ST_MUL_MA,
        ST_DIV_A,
        ST_MUL_MT,
        ST_DIV_J,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

### rtl/core/pgfj_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pgfj_front
    import pgfj_pkg::*;
#(
    parameter int DIMENSIONS = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   opcode,
    input  logic [IDW-1:0]         particle_id,
    input  logic [AXES-1:0][31:0]  pos,
    input  logic [AXES-1:0][31:0]  vel,
    input  logic [31:0]            mass,
    input  logic                   last,
    output logic                   q_wr,
    output entry_t                 q_data,
    input  logic                   q_full
);

    logic [AXES-1:0][31:0] tpos_reg;
    logic [AXES-1:0][31:0] tvel_reg;
    logic [IDW-1:0]        tid_reg;

    assign full = q_full;
    assign q_wr = push && !q_full;

    always_comb
    begin
        if (opcode == OP_LOAD)
        begin
            q_data.kind = KIND_LOAD;
        end
        else if (particle_id == tid_reg)
        begin
            q_data.kind = KIND_SKIP;
        end
        else
        begin
            q_data.kind = KIND_NEIGHBOUR;
        end
        q_data.last = last;
        q_data.mass = mass;
        for (int k = 0; k < AXES; k++)
        begin
            if (k < DIMENSIONS)
            begin
                q_data.dx[k] = {pos[k][31], pos[k]} - {tpos_reg[k][31], tpos_reg[k]};
                q_data.dv[k] = {vel[k][31], vel[k]} - {tvel_reg[k][31], tvel_reg[k]};
            end
            else
            begin
                q_data.dx[k] = '0;
                q_data.dv[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpos_reg <= '0;
            tvel_reg <= '0;
            tid_reg  <= '0;
        end
        else if (q_wr && opcode == OP_LOAD)
        begin
            tid_reg <= particle_id;
            for (int k = 0; k < AXES; k++)
            begin
                tpos_reg[k] <= (k < DIMENSIONS) ? pos[k] : 32'd0;
                tvel_reg[k] <= (k < DIMENSIONS) ? vel[k] : 32'd0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/pgfj_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pgfj_queue
    import pgfj_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    output logic   full,
    input  logic   rd_en,
    output entry_t rd_data,
    output logic   empty
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    entry_t         mem_reg [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;

    assign full    = (count_reg == (PW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/pgfj_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pgfj_div
    import pgfj_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [127:0]     num,
    input  logic [DENW-1:0]  den,
    output logic             done,
    output logic [63:0]      quo,
    output logic             ovf
);

    localparam int CW = $clog2(DIVSTEPS);

    logic [DENW-1:0] den_reg;
    logic [DENW-1:0] rem_reg;
    logic [63:0]     lo_reg;
    logic [63:0]     quo_reg;
    logic            ovf_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DENW:0]   trial;
    logic            fits;

    assign trial = {rem_reg, lo_reg[63]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;
    assign ovf   = ovf_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= DENW'(num[127:64]);
            lo_reg  <= num[63:0];
            ovf_reg <= (DENW'(num[127:64]) >= den);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DENW'(trial - {1'b0, den_reg}) : trial[DENW-1:0];
            lo_reg  <= {lo_reg[62:0], 1'b0};
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIVSTEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pgfj_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pgfj_back
    import pgfj_pkg::*;
#(
    parameter int DIMENSIONS = 3
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [31:0]  softening,
    input  logic         q_empty,
    input  entry_t       q_data,
    output logic         q_pop,
    output result_t      res,
    output logic         res_valid,
    input  logic         res_pop
);

    localparam int SQCW = $clog2(ROOTW);
    localparam logic [63:0] Q_LIMIT = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic             mul_go;
        logic [63:0]      mul_a;
        logic [63:0]      mul_b;
        logic             div_go;
        logic [127:0]     div_num;
        logic [DENW-1:0]  div_den;
        logic             pop;
        logic             res_load;
    } ctl_t;

    function automatic logic [64:0] make_term(input logic [63:0] q, input logic ovf,
                                              input logic neg);
        logic [63:0] lim;
        logic [63:0] v;
        logic        clamp;
        lim   = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        clamp = ovf || (q > lim);
        v     = clamp ? lim : q;
        return {clamp, neg ? (~v + 64'd1) : v};
    endfunction

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        end
        return {1'b0, s[63:0]};
    endfunction

    state_t                state_reg;
    state_t                state_next;
    ctl_t                  ctl;
    logic                  issued_reg;
    logic [AXW-1:0]        k_reg;
    entry_t                item_reg;
    logic [DW-1:0]         d_reg;
    logic [SW-1:0]         s_reg;
    logic [SQNW-1:0]       sq_n_reg;
    logic [ROOTW:0]        sq_rem_reg;
    logic [ROOTW-1:0]      sq_root_reg;
    logic [SQCW-1:0]       sq_cnt_reg;
    logic [DENW-1:0]       den_reg;
    logic [63:0]           t_reg;
    logic [AXES-1:0][63:0] acc_sum_reg;
    logic [AXES-1:0][63:0] jerk_sum_reg;
    logic                  sat_reg;
    result_t               res_reg;
    logic                  res_valid_reg;

    logic [63:0]           mul_a_reg;
    logic [63:0]           mul_b_reg;
    logic [63:0]           mul_pp_reg;
    logic [1:0]            mul_sh_reg;
    logic [127:0]          mul_acc_reg;
    logic [2:0]            mul_cnt_reg;
    logic                  mul_busy_reg;
    logic                  mul_done_reg;
    logic [31:0]           pp_a;
    logic [31:0]           pp_b;
    logic [127:0]          pp_shifted;

    logic                  div_done;
    logic [63:0]           div_quo;
    logic                  div_ovf;

    logic [DIFFW-1:0]      dx_k;
    logic [DIFFW-1:0]      dv_k;
    logic [DIFFW-1:0]      dx_abs;
    logic [DIFFW-1:0]      dv_abs;
    logic                  dx_neg;
    logic                  dv_neg;
    logic [31:0]           ax;
    logic [31:0]           av;
    logic                  s_neg;
    logic [SW-1:0]         s_abs;
    logic                  t_neg;
    logic [63:0]           t_abs;
    logic                  axis_last;
    logic [DW-1:0]         d_floor;
    logic [SQNW/ROOTW*0+ROOTW+2:0] sq_rem2;
    logic [ROOTW+2:0]      sq_trial;
    logic                  sq_fits;
    logic [63:0]           qm;
    logic [63:0]           dv_ext;
    logic [64:0]           term;
    logic [64:0]           sum_a;
    logic [64:0]           sum_j;

    assign dx_k   = item_reg.dx[k_reg];
    assign dv_k   = item_reg.dv[k_reg];
    assign dx_neg = dx_k[DIFFW-1];
    assign dv_neg = dv_k[DIFFW-1];
    assign dx_abs = dx_neg ? (~dx_k + 1'b1) : dx_k;
    assign dv_abs = dv_neg ? (~dv_k + 1'b1) : dv_k;
    assign ax     = dx_abs[31:0];
    assign av     = dv_abs[31:0];
    assign s_neg  = s_reg[SW-1];
    assign s_abs  = s_neg ? (~s_reg + 1'b1) : s_reg;
    assign t_neg  = t_reg[63];
    assign t_abs  = t_neg ? (~t_reg + 64'd1) : t_reg;
    assign axis_last = (k_reg == AXW'(DIMENSIONS - 1));
    assign d_floor   = (d_reg < DW'(softening)) ? DW'(softening) : d_reg;

    assign sq_rem2  = {sq_rem_reg, sq_n_reg[SQNW-1:SQNW-2]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_fits  = (sq_rem2 >= sq_trial);

    assign qm     = (div_ovf || div_quo > Q_LIMIT) ? Q_LIMIT : div_quo;
    assign dv_ext = 64'($signed(dv_k));
    assign term   = make_term(div_quo, div_ovf, (state_reg == ST_DIV_A) ? dx_neg : t_neg);
    assign sum_a  = sat_add(acc_sum_reg[k_reg], term[63:0]);
    assign sum_j  = sat_add(jerk_sum_reg[k_reg], term[63:0]);

    assign q_pop     = ctl.pop;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_data.kind == KIND_NEIGHBOUR) ? ST_MUL_XX : ST_FINISH;
                end
            end
            ST_MUL_XX:
            begin
                if (mul_done_reg)
                begin
                    state_next = ST_MUL_XV;
                end
            end
            ST_MUL_XV:
            begin
                if (mul_done_reg)
                begin
                    state_next = axis_last ? ST_FLOOR : ST_MUL_XX;
                end
            end
            ST_FLOOR:
            begin
                state_next = (d_floor == '0) ? ST_FINISH : ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sq_cnt_reg == SQCW'(ROOTW - 1))
                begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                if (mul_done_reg)
                begin
                    state_next = ST_MUL_XS;
                end
            end
            ST_MUL_XS:
            begin
                if (mul_done_reg)
                begin
                    state_next = ST_DIV_Q;
                end
            end
            ST_DIV_Q:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_MA;
                end
            end
            ST_MUL_MA:
            begin
                if (mul_done_reg)
                begin
                    state_next = ST_DIV_A;
                end
            end
            ST_DIV_A:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_MT;
                end
            end
            ST_MUL_MT:
            begin
                if (mul_done_reg)
                begin
                    state_next = ST_DIV_J;
                end
            end
            ST_DIV_J:
            begin
                if (div_done)
                begin
                    state_next = axis_last ? ST_FINISH : ST_MUL_XS;
                end
            end
            ST_FINISH:
            begin
                if (!item_reg.last || !res_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.mul_go   = (state_reg inside {ST_MUL_XX, ST_MUL_XV, ST_DEN, ST_MUL_XS,
                                          ST_MUL_MA, ST_MUL_MT}) && !issued_reg;
        ctl.div_go   = (state_reg inside {ST_DIV_Q, ST_DIV_A, ST_DIV_J}) && !issued_reg;
        ctl.pop      = (state_reg == ST_IDLE) && !q_empty;
        ctl.res_load = (state_reg == ST_FINISH) && item_reg.last && !res_valid_reg;
        ctl.div_num  = {mul_acc_reg[95:0], 32'd0};
        ctl.div_den  = den_reg;
        ctl.mul_a    = 64'(ax);
        ctl.mul_b    = 64'(ax);
        case (state_reg)
            ST_MUL_XV:
            begin
                ctl.mul_b = 64'(av);
            end
            ST_DEN:
            begin
                ctl.mul_a = 64'(d_reg);
                ctl.mul_b = 64'(sq_root_reg);
            end
            ST_MUL_XS:
            begin
                ctl.mul_b = 64'(s_abs);
            end
            ST_MUL_MA:
            begin
                ctl.mul_a = 64'(item_reg.mass);
            end
            ST_MUL_MT:
            begin
                ctl.mul_a = 64'(item_reg.mass);
                ctl.mul_b = t_abs;
            end
            ST_DIV_Q:
            begin
                ctl.div_num = mul_acc_reg + {mul_acc_reg[126:0], 1'b0};
                ctl.div_den = DENW'(d_reg);
            end
            default:
            begin
                ctl.mul_a = 64'(ax);
            end
        endcase
    end

    always_comb
    begin
        case (mul_cnt_reg[1:0])
            2'd0:
            begin
                pp_a = mul_a_reg[31:0];
                pp_b = mul_b_reg[31:0];
            end
            2'd1:
            begin
                pp_a = mul_a_reg[31:0];
                pp_b = mul_b_reg[63:32];
            end
            2'd2:
            begin
                pp_a = mul_a_reg[63:32];
                pp_b = mul_b_reg[31:0];
            end
            default:
            begin
                pp_a = mul_a_reg[63:32];
                pp_b = mul_b_reg[63:32];
            end
        endcase
        case (mul_sh_reg)
            2'd0:    pp_shifted = {64'd0, mul_pp_reg};
            2'd1,
            2'd2:    pp_shifted = {32'd0, mul_pp_reg, 32'd0};
            default: pp_shifted = {mul_pp_reg, 64'd0};
        endcase
    end

    pgfj_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_go),
        .num   (ctl.div_num),
        .den   (ctl.div_den),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.mul_go)
        begin
            mul_a_reg   <= ctl.mul_a;
            mul_b_reg   <= ctl.mul_b;
            mul_acc_reg <= '0;
        end
        else if (mul_busy_reg)
        begin
            if (mul_cnt_reg != 3'd4)
            begin
                mul_pp_reg <= pp_a * pp_b;
                mul_sh_reg <= mul_cnt_reg[1:0];
            end
            if (mul_cnt_reg != 3'd0)
            begin
                mul_acc_reg <= mul_acc_reg + pp_shifted;
            end
        end

        if (ctl.pop)
        begin
            item_reg <= q_data;
            d_reg    <= '0;
            s_reg    <= '0;
        end

        case (state_reg)
            ST_MUL_XX:
            begin
                if (mul_done_reg)
                begin
                    d_reg <= d_reg + DW'(mul_acc_reg[63:16]);
                end
            end
            ST_MUL_XV:
            begin
                if (mul_done_reg)
                begin
                    s_reg <= (dx_neg != dv_neg) ? s_reg - SW'(mul_acc_reg[63:16])
                                                : s_reg + SW'(mul_acc_reg[63:16]);
                end
            end
            ST_FLOOR:
            begin
                d_reg       <= d_floor;
                sq_n_reg    <= {d_floor, 16'd0};
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                sq_cnt_reg  <= '0;
            end
            ST_ROOT:
            begin
                sq_n_reg    <= {sq_n_reg[SQNW-3:0], 2'b00};
                sq_rem_reg  <= sq_fits ? (ROOTW+1)'(sq_rem2 - sq_trial)
                                       : sq_rem2[ROOTW:0];
                sq_root_reg <= {sq_root_reg[ROOTW-2:0], sq_fits};
                sq_cnt_reg  <= sq_cnt_reg + 1'b1;
            end
            ST_DEN:
            begin
                if (mul_done_reg)
                begin
                    den_reg <= mul_acc_reg[DENW-1:0];
                end
            end
            ST_DIV_Q:
            begin
                if (div_done)
                begin
                    t_reg <= (dx_neg != s_neg) ? dv_ext + qm : dv_ext - qm;
                end
            end
            default:
            begin
            end
        endcase

        if (ctl.res_load)
        begin
            res_reg.acc  <= acc_sum_reg;
            res_reg.jerk <= jerk_sum_reg;
            res_reg.sat  <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            k_reg         <= '0;
            mul_cnt_reg   <= '0;
            mul_busy_reg  <= 1'b0;
            mul_done_reg  <= 1'b0;
            acc_sum_reg   <= '0;
            jerk_sum_reg  <= '0;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (ctl.mul_go || ctl.div_go)
            begin
                issued_reg <= 1'b1;
            end
            else if (mul_done_reg || div_done)
            begin
                issued_reg <= 1'b0;
            end

            if (ctl.mul_go)
            begin
                mul_cnt_reg  <= '0;
                mul_busy_reg <= 1'b1;
                mul_done_reg <= 1'b0;
            end
            else if (mul_busy_reg)
            begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == 3'd4)
                begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
            else
            begin
                mul_done_reg <= 1'b0;
            end

            if (ctl.pop)
            begin
                k_reg <= '0;
                if (q_data.kind == KIND_LOAD)
                begin
                    acc_sum_reg  <= '0;
                    jerk_sum_reg <= '0;
                    sat_reg      <= 1'b0;
                end
            end

            if (state_reg == ST_MUL_XV && mul_done_reg)
            begin
                k_reg <= axis_last ? '0 : k_reg + 1'b1;
            end

            if (state_reg == ST_DIV_A && div_done)
            begin
                acc_sum_reg[k_reg] <= sum_a[63:0];
                sat_reg            <= sat_reg | term[64] | sum_a[64];
            end

            if (state_reg == ST_DIV_J && div_done)
            begin
                jerk_sum_reg[k_reg] <= sum_j[63:0];
                sat_reg             <= sat_reg | term[64] | sum_j[64];
                if (!axis_last)
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end

            if (ctl.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/pairwise_gravity_force_jerk_accumulator.sv
// A load or self item passes through the back end's idle and finish states; when it is
// marked last and the result slot is free, its sums are registered onto the result ports.
// A neighbour runs multiply states per axis, a square root, then multiply and divide states
// per axis, or goes from the floor state to finish when its softened separation is zero; the 64-step
// divider, used three times per axis, dominates its run time. Two items can wait in the input queue.
// rst_n clears the target, the sums, the flag, the input queue and the softening register at once.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_gravity_force_jerk_accumulator
    import pgfj_pkg::*;
#(
    parameter int DIMENSIONS = 3
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    input  logic         push,
    output logic         full,
    input  logic         opcode,
    input  logic [23:0]  particle_id,
    input  logic [31:0]  pos_x,
    input  logic [31:0]  pos_y,
    input  logic [31:0]  pos_z,
    input  logic [31:0]  vel_x,
    input  logic [31:0]  vel_y,
    input  logic [31:0]  vel_z,
    input  logic [31:0]  mass,
    input  logic         last,
    output logic         empty,
    input  logic         pop,
    output logic [63:0]  acc_x,
    output logic [63:0]  acc_y,
    output logic [63:0]  acc_z,
    output logic [63:0]  jerk_x,
    output logic [63:0]  jerk_y,
    output logic [63:0]  jerk_z,
    output logic         saturated
);

    logic [31:0] softening_reg;
    logic        q_wr;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    entry_t      q_wr_data;
    entry_t      q_rd_data;
    result_t     res;
    logic        res_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            softening_reg <= '0;
        end
        else if (cfg_valid)
        begin
            softening_reg <= cfg_data;
        end
    end

    pgfj_front #(
        .DIMENSIONS (DIMENSIONS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .particle_id (particle_id),
        .pos         ({pos_z, pos_y, pos_x}),
        .vel         ({vel_z, vel_y, vel_x}),
        .mass        (mass),
        .last        (last),
        .q_wr        (q_wr),
        .q_data      (q_wr_data),
        .q_full      (q_full)
    );

    pgfj_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    pgfj_back #(
        .DIMENSIONS (DIMENSIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .softening (softening_reg),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty     = !res_valid;
    assign acc_x     = res.acc[0];
    assign acc_y     = res.acc[1];
    assign acc_z     = res.acc[2];
    assign jerk_x    = res.jerk[0];
    assign jerk_y    = res.jerk[1];
    assign jerk_z    = res.jerk[2];
    assign saturated = res.sat;

`ifndef NO_ASSERTIONS
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> !q_full)
        else $error("Queue written while full.");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("Queue read while empty.");

    a_fill_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_full) |-> $past(q_wr))
        else $error("Queue became full without a write.");
`endif

endmodule

`default_nettype wire
